// File: hdl/gamepad_frame_to_events_defines.svh
// Assertion macros for the gamepad frame-to-events block.
// Used by the top level only; expects clk_i and rst_ni in scope.
`ifndef GAMEPAD_FRAME_TO_EVENTS_DEFINES_SVH
`define GAMEPAD_FRAME_TO_EVENTS_DEFINES_SVH

// Same-cycle implication.
`define GFTE_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("gfte same-cycle check failed");

// Next-cycle implication.
`define GFTE_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("gfte next-cycle check failed");

`endif

// File: hdl/gfte_pkg.sv
`timescale 1ns / 1ps
// Package for the gamepad frame-to-events block: constants, codes, payload types.
// No dependencies.
package gfte_pkg;

  localparam int BUTTON_BITS = 16;
  localparam int BTN_IDX_W   = (BUTTON_BITS > 1) ? $clog2(BUTTON_BITS) : 1;

  localparam logic [15:0] CRC_POLY = 16'h1021;
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam int CRC_BITS_PER_STEP = 2;
  localparam int CRC_STEPS         = 8 / CRC_BITS_PER_STEP;
  localparam int CRC_CNT_W         = (CRC_STEPS > 1) ? $clog2(CRC_STEPS) : 1;

  // Byte position within a frame
  localparam logic [3:0] POS_WAIT     = 4'd0;
  localparam logic [3:0] POS_FIRST    = 4'd1;
  localparam logic [3:0] POS_LAST_CRC = 4'd6;  // last byte covered by the CRC
  localparam logic [3:0] POS_CRC_LO   = 4'd7;
  localparam logic [3:0] POS_CRC_HI   = 4'd8;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 40;
  localparam int MAP_W      = 5;
  localparam logic [CFG_IDX_W-1:0] CFG_MAP_LOW   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAP_HIGH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STICK_CNT = 2'd2;
  localparam logic [CFG_DATA_W-1:0] MAP_RESET    = 40'hFF_FFFF_FFFF;
  localparam logic [1:0] STICKS_LEFT = 2'd1;
  localparam logic [1:0] STICKS_BOTH = 2'd2;

  // Targets and axes
  localparam logic [MAP_W-1:0] TGT_MAX        = 5'd16;
  localparam logic [MAP_W-1:0] TGT_LTRIG_BTN  = 5'd6;
  localparam logic [MAP_W-1:0] TGT_RTRIG_BTN  = 5'd7;
  localparam logic [4:0] AXIS_LX    = 5'd0;
  localparam logic [4:0] AXIS_LY    = 5'd1;
  localparam logic [4:0] AXIS_LTRIG = 5'd2;
  localparam logic [4:0] AXIS_RX    = 5'd3;
  localparam logic [4:0] AXIS_RY    = 5'd4;
  localparam logic [4:0] AXIS_RTRIG = 5'd5;
  localparam logic [7:0] AXIS_FULL  = 8'hFF;

  typedef enum logic [1:0] {
    EV_BUTTON = 2'd0,
    EV_AXIS   = 2'd1,
    EV_SYNC   = 2'd2
  } event_kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CRC,
    ST_BTN,
    ST_TRIG,
    ST_STICK,
    ST_SYNC
  } state_e;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       frame_start;
  } in_item_t;

  typedef struct packed {
    logic [1:0] event_kind;
    logic [4:0] event_index;
    logic [7:0] event_value;
    logic       last_event;
  } out_item_t;

  function automatic logic [4:0] axis_of_stick(input logic [1:0] stick);
    logic [4:0] axis;
    case (stick)
      2'd0:    axis = AXIS_LX;
      2'd1:    axis = AXIS_LY;
      2'd2:    axis = AXIS_RX;
      default: axis = AXIS_RY;
    endcase
    return axis;
  endfunction

endpackage

// File: hdl/gfte_crc_step.sv
`timescale 1ns / 1ps
// Shared CRC-16 shift unit: advances the register by CRC_BITS_PER_STEP bits, MSB first.
// Depends on gfte_pkg.
module gfte_crc_step (
  input  logic [15:0] crc_i,
  output logic [15:0] crc_o
);

  always_comb begin
    logic [15:0] c;
    c = crc_i;
    for (int k = 0; k < gfte_pkg::CRC_BITS_PER_STEP; k++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ gfte_pkg::CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    crc_o = c;
  end

endmodule

// File: hdl/gamepad_frame_to_events.sv
`timescale 1ns / 1ps
// Gamepad frame-to-events converter, top level.
// Depends on gfte_pkg, gfte_crc_step and gamepad_frame_to_events_defines.svh.
//
// Usage:
//   Input channel (in_valid_i/in_ready_o/in_data_i) takes one report byte per
//   transaction; frame_start marks byte 0 of a 9-byte frame. Output channel
//   (out_valid_o/out_ready_i/out_data_o) delivers button, axis and sync events.
//   Config port (cfg_we_i/cfg_index_i/cfg_data_i) writes the two button maps
//   and the stick count, one per write; write it only while the block is idle.
// Sequence:
//   Frame bytes 0-6 each run through the shared 2-bit CRC shifter after
//   acceptance; bytes 7 and 8 are taken without a CRC pass.
//   After a good byte 8 the scan sequencer walks BUTTON_BITS button slots,
//   with an extra trigger step per trigger event, then 4 sticks and one
//   sync slot; a stalled output holds the scan in place.
//   in_ready_o is high only while idle.
// Reset: byte position goes to waiting-for-start, CRC to 0xFFFF, previous
//   buttons and sticks to zero, maps to all-unmapped, stick count to two.
// Stall: one output register; a stalled receiver holds the scan in place.
`include "gamepad_frame_to_events_defines.svh"

module gamepad_frame_to_events (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  gfte_pkg::in_item_t                  in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output gfte_pkg::out_item_t                 out_data_o,
  input  logic                                cfg_we_i,
  input  logic [gfte_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [gfte_pkg::CFG_DATA_W-1:0]     cfg_data_i
);

  gfte_pkg::state_e state_q, state_d;

  // Byte framing and CRC
  logic [3:0]                     pos_q, pos_d;
  logic [15:0]                    crc_q, crc_d, crc_next;
  logic [gfte_pkg::CRC_CNT_W-1:0] step_q, step_d;
  logic [7:0]                     frame_q [8];
  logic                           frame_we;
  logic [2:0]                     frame_waddr;

  // Previous values and scan counters
  logic [15:0]                    prev_btn_q, prev_btn_d;
  logic [7:0]                     prev_stk_q [4];
  logic                           prev_upd;
  logic [gfte_pkg::BTN_IDX_W-1:0] btn_q, btn_d;
  logic [1:0]                     stk_q, stk_d;
  logic                           any_q, any_d;

  // Output register
  logic                  out_valid_q, out_valid_d;
  gfte_pkg::out_item_t   out_data_q, out_data_d;
  logic                  emit;
  gfte_pkg::out_item_t   emit_data;

  // Configuration
  logic [gfte_pkg::CFG_DATA_W-1:0] map_lo_q, map_hi_q;
  logic [1:0]                      stick_cnt_q;

  logic in_acc, slot_free;
  assign in_ready_o  = (state_q == gfte_pkg::ST_IDLE);
  assign in_acc      = in_valid_i && in_ready_o;
  assign slot_free   = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  gfte_crc_step u_crc (
    .crc_i(crc_q),
    .crc_o(crc_next)
  );

  // Frame check: CRC bytes arrive little-endian
  logic crc_ok;
  assign crc_ok = ({in_data_i.rx_byte, frame_q[7]} == crc_q);

  // Button slot under inspection
  logic [15:0]                  cur_btn, changed;
  logic [3:0]                   btn_bit;
  logic [7:0][gfte_pkg::MAP_W-1:0] map_fields;
  logic [gfte_pkg::MAP_W-1:0]   tgt;
  logic                         pressed, btn_hit, btn_trig, btn_last;

  assign cur_btn    = {frame_q[1], frame_q[0]};
  assign changed    = cur_btn ^ prev_btn_q;
  assign btn_bit    = 4'(btn_q);
  assign map_fields = btn_bit[3] ? map_hi_q : map_lo_q;
  assign tgt        = map_fields[btn_bit[2:0]];
  assign pressed    = cur_btn[btn_bit];
  assign btn_hit    = changed[btn_bit] && (tgt <= gfte_pkg::TGT_MAX);
  assign btn_trig   = (tgt == gfte_pkg::TGT_LTRIG_BTN) || (tgt == gfte_pkg::TGT_RTRIG_BTN);
  assign btn_last   = (btn_q == gfte_pkg::BTN_IDX_W'(gfte_pkg::BUTTON_BITS - 1));

  // Stick slot under inspection; sticks sit at frame bytes 2-5
  logic [7:0] stk_val;
  logic [1:0] stk_needed;
  logic       stk_hit;
  assign stk_val    = frame_q[{1'b0, stk_q} + 3'd2];
  assign stk_needed = stk_q[1] ? gfte_pkg::STICKS_BOTH : gfte_pkg::STICKS_LEFT;
  assign stk_hit    = (stick_cnt_q >= stk_needed) && (stk_val != prev_stk_q[stk_q]);

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      gfte_pkg::ST_IDLE: begin
        if (in_acc) begin
          if (in_data_i.frame_start) begin
            state_d = gfte_pkg::ST_CRC;
          end else if (pos_q inside {[gfte_pkg::POS_FIRST:gfte_pkg::POS_LAST_CRC]}) begin
            state_d = gfte_pkg::ST_CRC;
          end else if (pos_q == gfte_pkg::POS_CRC_HI && crc_ok) begin
            state_d = gfte_pkg::ST_BTN;
          end
        end
      end
      gfte_pkg::ST_CRC: begin
        if (step_q == gfte_pkg::CRC_CNT_W'(gfte_pkg::CRC_STEPS - 1)) begin
          state_d = gfte_pkg::ST_IDLE;
        end
      end
      gfte_pkg::ST_BTN: begin
        if (!btn_hit || slot_free) begin
          if (btn_hit && btn_trig) begin
            state_d = gfte_pkg::ST_TRIG;
          end else if (btn_last) begin
            state_d = gfte_pkg::ST_STICK;
          end
        end
      end
      gfte_pkg::ST_TRIG: begin
        if (slot_free) begin
          state_d = btn_last ? gfte_pkg::ST_STICK : gfte_pkg::ST_BTN;
        end
      end
      gfte_pkg::ST_STICK: begin
        if ((!stk_hit || slot_free) && stk_q == 2'd3) begin
          state_d = gfte_pkg::ST_SYNC;
        end
      end
      gfte_pkg::ST_SYNC: begin
        if (!any_q || slot_free) begin
          state_d = gfte_pkg::ST_IDLE;
        end
      end
      default: state_d = gfte_pkg::ST_IDLE;
    endcase
  end

  // Datapath and event generation
  always_comb begin
    pos_d       = pos_q;
    crc_d       = crc_q;
    step_d      = step_q;
    btn_d       = btn_q;
    stk_d       = stk_q;
    any_d       = any_q;
    frame_we    = 1'b0;
    frame_waddr = pos_q[2:0];
    prev_upd    = 1'b0;
    emit        = 1'b0;
    emit_data   = '0;
    case (state_q)
      gfte_pkg::ST_IDLE: begin
        if (in_acc) begin
          if (in_data_i.frame_start) begin
            frame_we    = 1'b1;
            frame_waddr = 3'd0;
            crc_d       = gfte_pkg::CRC_INIT ^ {in_data_i.rx_byte, 8'h00};
            pos_d       = gfte_pkg::POS_FIRST;
            step_d      = '0;
          end else if (pos_q == gfte_pkg::POS_WAIT || pos_q > gfte_pkg::POS_CRC_HI) begin
            pos_d = gfte_pkg::POS_WAIT;
          end else if (pos_q <= gfte_pkg::POS_LAST_CRC) begin
            frame_we = 1'b1;
            crc_d    = crc_q ^ {in_data_i.rx_byte, 8'h00};
            pos_d    = pos_q + 4'd1;
            step_d   = '0;
          end else if (pos_q == gfte_pkg::POS_CRC_LO) begin
            frame_we = 1'b1;
            pos_d    = gfte_pkg::POS_CRC_HI;
          end else begin
            pos_d = gfte_pkg::POS_WAIT;
            crc_d = gfte_pkg::CRC_INIT;
            btn_d = '0;
            stk_d = '0;
            any_d = 1'b0;
          end
        end
      end
      gfte_pkg::ST_CRC: begin
        crc_d  = crc_next;
        step_d = step_q + 1'b1;
      end
      gfte_pkg::ST_BTN: begin
        if (btn_hit && slot_free) begin
          emit                  = 1'b1;
          emit_data.event_kind  = gfte_pkg::EV_BUTTON;
          emit_data.event_index = tgt;
          emit_data.event_value = {7'd0, pressed};
          any_d                 = 1'b1;
        end
        if ((!btn_hit || slot_free) && !(btn_hit && btn_trig)) begin
          btn_d = btn_q + 1'b1;
        end
      end
      gfte_pkg::ST_TRIG: begin
        if (slot_free) begin
          emit                  = 1'b1;
          emit_data.event_kind  = gfte_pkg::EV_AXIS;
          emit_data.event_index = (tgt == gfte_pkg::TGT_LTRIG_BTN) ? gfte_pkg::AXIS_LTRIG
                                                                   : gfte_pkg::AXIS_RTRIG;
          emit_data.event_value = pressed ? gfte_pkg::AXIS_FULL : 8'd0;
          btn_d                 = btn_q + 1'b1;
        end
      end
      gfte_pkg::ST_STICK: begin
        if (stk_hit && slot_free) begin
          emit                  = 1'b1;
          emit_data.event_kind  = gfte_pkg::EV_AXIS;
          emit_data.event_index = gfte_pkg::axis_of_stick(stk_q);
          emit_data.event_value = stk_val;
          any_d                 = 1'b1;
        end
        if (!stk_hit || slot_free) begin
          stk_d = stk_q + 2'd1;
        end
      end
      gfte_pkg::ST_SYNC: begin
        if (any_q && slot_free) begin
          emit                 = 1'b1;
          emit_data.event_kind = gfte_pkg::EV_SYNC;
          emit_data.last_event = 1'b1;
        end
        if (!any_q || slot_free) begin
          prev_upd = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // Output register and previous-value update
  always_comb begin
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    if (emit) begin
      out_valid_d = 1'b1;
      out_data_d  = emit_data;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    prev_btn_d = prev_upd ? cur_btn : prev_btn_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= gfte_pkg::ST_IDLE;
      pos_q       <= gfte_pkg::POS_WAIT;
      crc_q       <= gfte_pkg::CRC_INIT;
      step_q      <= '0;
      btn_q       <= '0;
      stk_q       <= '0;
      any_q       <= 1'b0;
      out_valid_q <= 1'b0;
      prev_btn_q  <= '0;
      for (int i = 0; i < 4; i++) begin
        prev_stk_q[i] <= '0;
      end
      map_lo_q    <= gfte_pkg::MAP_RESET;
      map_hi_q    <= gfte_pkg::MAP_RESET;
      stick_cnt_q <= gfte_pkg::STICKS_BOTH;
    end else begin
      state_q     <= state_d;
      pos_q       <= pos_d;
      crc_q       <= crc_d;
      step_q      <= step_d;
      btn_q       <= btn_d;
      stk_q       <= stk_d;
      any_q       <= any_d;
      out_valid_q <= out_valid_d;
      prev_btn_q  <= prev_btn_d;
      if (prev_upd) begin
        for (int i = 0; i < 4; i++) begin
          prev_stk_q[i] <= frame_q[i + 2];
        end
      end
      if (cfg_we_i) begin
        case (cfg_index_i)
          gfte_pkg::CFG_MAP_LOW:   map_lo_q    <= cfg_data_i;
          gfte_pkg::CFG_MAP_HIGH:  map_hi_q    <= cfg_data_i;
          gfte_pkg::CFG_STICK_CNT: stick_cnt_q <= cfg_data_i[1:0];
          default: ;
        endcase
      end
    end
  end

  // Payload registers, no reset
  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
    if (frame_we) begin
      frame_q[frame_waddr] <= in_data_i.rx_byte;
    end
  end

  // Checks
  `GFTE_ASSERT_SAME(a_last_is_sync, out_valid_o && out_data_o.last_event,
                    out_data_o.event_kind == gfte_pkg::EV_SYNC)
  `GFTE_ASSERT_SAME(a_button_index, out_valid_o && out_data_o.event_kind == gfte_pkg::EV_BUTTON,
                    out_data_o.event_index <= gfte_pkg::TGT_MAX)
  `GFTE_ASSERT_NEXT(a_crc_done, state_q == gfte_pkg::ST_CRC
                    && step_q == gfte_pkg::CRC_CNT_W'(gfte_pkg::CRC_STEPS - 1),
                    state_q == gfte_pkg::ST_IDLE)
  `GFTE_ASSERT_NEXT(a_bad_frame_dropped, in_acc && !in_data_i.frame_start
                    && pos_q == gfte_pkg::POS_CRC_HI && !crc_ok,
                    state_q == gfte_pkg::ST_IDLE && pos_q == gfte_pkg::POS_WAIT)

endmodule
